>>> sv/tst_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Timer slot table package
// Shared types and constants for the timer slot table controller and datapath.
// ----------------------------------------------------------------------------
package tst_pkg;

  localparam int unsigned MaxResults   = 16;
  localparam int unsigned RepW         = $clog2(MaxResults + 1);
  localparam logic [15:0] TickStepInit = 16'd10;

  typedef enum logic [1:0] {
    OP_CREATE  = 2'd0,
    OP_RELEASE = 2'd1,
    OP_CANCEL  = 2'd2,
    OP_TICK    = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    STS_OK       = 3'd0,
    STS_FIRED    = 3'd1,
    STS_FULL     = 3'd2,
    STS_NONE     = 3'd3,
    STS_NOT_USED = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_SCAN,
    S_DRAIN,
    S_REPORT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic cap;      // capture the request fields
    logic do_rc;    // execute release or cancel on the incoming request
    logic do_tick;  // advance the tick count and reset the report state
    logic cnt_clr;  // clear the slot counter
    logic cnt_inc;  // step the slot counter
    logic alloc;    // allocate the slot at the counter
    logic full;     // answer table full
    logic scan;     // read the slot at the counter for evaluation
    logic report;   // issue the final result of a tick
  } tst_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic free_here;  // slot at the counter is free
    logic cnt_end;    // counter is on the highest slot
  } tst_sts_t;

endpackage
`default_nettype wire

>>> sv/tst_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Timer slot table controller
// Sequences the free-slot search for create and the slot scan for tick.
// ----------------------------------------------------------------------------
module tst_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [1:0]        operation_i,
  input  tst_pkg::tst_sts_t      sts_i,
  output tst_pkg::tst_cmd_t      cmd_o,
  output logic                   busy_o
);
  import tst_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = (state_q != S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.cap     = 1'b1;
          cmd_o.cnt_clr = 1'b1;
          case (op_e'(operation_i))
            OP_CREATE: begin
              state_d = S_FIND;
            end
            OP_TICK: begin
              cmd_o.do_tick = 1'b1;
              state_d       = S_SCAN;
            end
            OP_RELEASE, OP_CANCEL: begin
              cmd_o.do_rc = 1'b1;
            end
            default: begin
              cmd_o.do_rc = 1'b1;
            end
          endcase
        end
      end
      S_FIND: begin
        if (sts_i.free_here) begin
          cmd_o.alloc = 1'b1;
          state_d     = S_IDLE;
        end else if (sts_i.cnt_end) begin
          cmd_o.full = 1'b1;
          state_d    = S_IDLE;
        end else begin
          cmd_o.cnt_inc = 1'b1;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.cnt_end) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // The last slot read is evaluated here.
        state_d = S_REPORT;
      end
      S_REPORT: begin
        cmd_o.report = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // A tick scan always ends in a drain and a final report.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && sts_i.cnt_end) |=> (state_q == S_DRAIN) ##1 (state_q == S_REPORT))
    else $error("tick scan did not end with drain and report");

  // Only the idle state accepts requests.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.cap |-> (state_q == S_IDLE && !busy_o))
    else $error("request captured while busy");

  // Allocation and table full are exclusive outcomes of the search.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.full |-> (!sts_i.free_here && sts_i.cnt_end))
    else $error("table full reported with a free slot");

endmodule
`default_nettype wire

>>> sv/tst_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Timer slot table datapath
// Tick count, slot storage, slot counter, scan evaluation and result register.
// ----------------------------------------------------------------------------
module tst_datapath #(
  parameter int unsigned NUM_SLOTS = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  tst_pkg::tst_cmd_t      cmd_i,
  output tst_pkg::tst_sts_t      sts_o,
  input  wire logic              tick_step_we_i,
  input  wire logic [15:0]       tick_step_i,
  input  wire logic [1:0]        operation_i,
  input  wire logic [31:0]       delay_i,
  input  wire logic              periodic_i,
  input  wire logic [3:0]        slot_i,
  output logic                   valid_o,
  output logic [2:0]             status_o,
  output logic [3:0]             slot_id_o,
  output logic                   last_o
);
  import tst_pkg::*;

  localparam int unsigned AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [AW-1:0] LastIdx = AW'(NUM_SLOTS - 1);

  logic [15:0]          step_q;
  logic [31:0]          tick_q;
  logic [NUM_SLOTS-1:0] in_use_q;
  logic [AW-1:0]        cnt_q;
  logic [31:0]          delay_q;
  logic                 periodic_q;

  logic [31:0] exp_mem  [NUM_SLOTS];
  logic        done_mem [NUM_SLOTS];
  logic        hold_mem [NUM_SLOTS];
  logic [31:0] exp_rd_q;
  logic        done_rd_q;
  logic        hold_rd_q;

  logic            eval_v_q;
  logic [AW-1:0]   eval_idx_q;
  logic            pend_v_q;
  logic [AW-1:0]   pend_idx_q;
  logic [RepW-1:0] nrep_q;

  logic        res_v_q;
  status_e     status_q;
  logic [3:0]  slot_id_q;
  logic        last_q;

  // Release and cancel decode on the incoming request.
  logic          rc_in_range;
  logic [AW-1:0] rc_idx;
  logic          rc_ok;
  logic          rc_cancel;

  // Scan evaluation of the slot read in the previous cycle.
  logic eval_live;
  logic fire;
  logic free_slot;
  logic rep_ok;

  logic          done_we;
  logic [AW-1:0] done_wa;
  logic          done_wd;
  logic          hold_we;
  logic [AW-1:0] hold_wa;
  logic          hold_wd;

  assign rc_in_range = (32'(slot_i) < NUM_SLOTS);
  assign rc_idx      = AW'(slot_i);
  assign rc_ok       = rc_in_range && in_use_q[rc_idx];
  assign rc_cancel   = (op_e'(operation_i) == OP_CANCEL);

  assign eval_live = eval_v_q && in_use_q[eval_idx_q];
  assign fire      = eval_live && !done_rd_q && ($signed(exp_rd_q) < $signed(tick_q));
  assign free_slot = eval_live && (done_rd_q || fire) && !hold_rd_q;
  assign rep_ok    = fire && (nrep_q < RepW'(MaxResults));

  assign sts_o.free_here = !in_use_q[cnt_q];
  assign sts_o.cnt_end   = (cnt_q == LastIdx);

  always_comb begin
    done_we = 1'b0;
    done_wa = cnt_q;
    done_wd = 1'b0;
    hold_we = 1'b0;
    hold_wa = cnt_q;
    hold_wd = periodic_q;
    if (cmd_i.alloc) begin
      done_we = 1'b1;
      hold_we = 1'b1;
    end else if (cmd_i.do_rc && rc_ok) begin
      hold_we = 1'b1;
      hold_wa = rc_idx;
      hold_wd = 1'b0;
      done_we = rc_cancel;
      done_wa = rc_idx;
      done_wd = 1'b1;
    end else if (fire) begin
      done_we = 1'b1;
      done_wa = eval_idx_q;
      done_wd = 1'b1;
    end
  end

  // Slot storage: one write and one read address per cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.alloc) begin
      exp_mem[cnt_q] <= tick_q + delay_q;
    end
    if (done_we) begin
      done_mem[done_wa] <= done_wd;
    end
    if (hold_we) begin
      hold_mem[hold_wa] <= hold_wd;
    end
    exp_rd_q  <= exp_mem[cnt_q];
    done_rd_q <= done_mem[cnt_q];
    hold_rd_q <= hold_mem[cnt_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      delay_q    <= delay_i;
      periodic_q <= periodic_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q     <= TickStepInit;
      tick_q     <= '0;
      in_use_q   <= '0;
      cnt_q      <= '0;
      eval_v_q   <= 1'b0;
      eval_idx_q <= '0;
      pend_v_q   <= 1'b0;
      pend_idx_q <= '0;
      nrep_q     <= '0;
    end else begin
      if (tick_step_we_i) begin
        step_q <= tick_step_i;
      end
      if (cmd_i.do_tick) begin
        tick_q   <= tick_q + {16'd0, step_q};
        pend_v_q <= 1'b0;
        nrep_q   <= '0;
      end
      if (cmd_i.cnt_clr) begin
        cnt_q <= '0;
      end else if (cmd_i.cnt_inc || cmd_i.scan) begin
        cnt_q <= cnt_q + AW'(1);
      end
      eval_v_q   <= cmd_i.scan;
      eval_idx_q <= cnt_q;
      if (cmd_i.alloc) begin
        in_use_q[cnt_q] <= 1'b1;
      end
      if (free_slot) begin
        in_use_q[eval_idx_q] <= 1'b0;
      end
      // A fired slot waits here until it is known whether it is the last one.
      if (rep_ok) begin
        pend_v_q   <= 1'b1;
        pend_idx_q <= eval_idx_q;
        nrep_q     <= nrep_q + RepW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_v_q <= 1'b0;
    end else begin
      res_v_q <= cmd_i.do_rc || cmd_i.alloc || cmd_i.full || cmd_i.report ||
                 (rep_ok && pend_v_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.do_rc) begin
      status_q  <= rc_ok ? STS_OK : STS_NOT_USED;
      slot_id_q <= slot_i;
      last_q    <= 1'b1;
    end else if (cmd_i.alloc) begin
      status_q  <= STS_OK;
      slot_id_q <= 4'(cnt_q);
      last_q    <= 1'b1;
    end else if (cmd_i.full) begin
      status_q  <= STS_FULL;
      slot_id_q <= '0;
      last_q    <= 1'b1;
    end else if (cmd_i.report) begin
      status_q  <= pend_v_q ? STS_FIRED : STS_NONE;
      slot_id_q <= pend_v_q ? 4'(pend_idx_q) : 4'd0;
      last_q    <= 1'b1;
    end else if (rep_ok && pend_v_q) begin
      status_q  <= STS_FIRED;
      slot_id_q <= 4'(pend_idx_q);
      last_q    <= 1'b0;
    end
  end

  assign valid_o   = res_v_q;
  assign status_o  = status_q;
  assign slot_id_o = slot_id_q;
  assign last_o    = last_q;

  // Only fired results can be followed by more results of the same request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_v_q && !last_q) |-> (status_q == STS_FIRED))
    else $error("non-final result that is not a firing");

  // The final report of a tick always comes out in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.report |=> (res_v_q && last_q))
    else $error("tick report missing");

  // The report count never passes the result limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    nrep_q <= RepW'(MaxResults))
    else $error("report count overflow");

  // A freshly allocated slot is live in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.alloc |=> in_use_q[$past(cnt_q)])
    else $error("allocated slot not marked in use");

endmodule
`default_nettype wire

>>> sv/timer_slot_table_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Timer slot table core
// Table of timer slots with create, release, cancel and tick operations.
// ----------------------------------------------------------------------------
// A request is taken when start_i is high and busy_o is low. Release and
// cancel complete in the accept cycle and leave busy_o low, so they can be
// issued back to back; their result is registered and appears in the next
// cycle. Create searches the in-use flags one slot per cycle from slot 0 and
// stops at the first free slot, or answers table full after the last slot.
// Tick reads the slot memory one slot per cycle and stays busy through the
// scan, a drain state and the final report. Every result is shown on the
// result ports for exactly one cycle with valid_o high and cannot be held
// off by the receiver; last_o marks the final result of a request. tick_step
// is written through tick_step_we_i and should only change while busy_o is
// low and no result is pending.
// ----------------------------------------------------------------------------
module timer_slot_table_core #(
  parameter int unsigned NUM_SLOTS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        tick_step_we_i,
  input  wire logic [15:0] tick_step_i,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [1:0]  operation_i,
  input  wire logic [31:0] delay_i,
  input  wire logic        periodic_i,
  input  wire logic [3:0]  slot_i,
  output logic             valid_o,
  output logic [2:0]       status_o,
  output logic [3:0]       slot_id_o,
  output logic             last_o
);
  import tst_pkg::*;

  tst_cmd_t cmd;
  tst_sts_t sts;

  tst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .operation_i (operation_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .busy_o      (busy_o)
  );

  tst_datapath #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .tick_step_we_i (tick_step_we_i),
    .tick_step_i    (tick_step_i),
    .operation_i    (operation_i),
    .delay_i        (delay_i),
    .periodic_i     (periodic_i),
    .slot_i         (slot_i),
    .valid_o        (valid_o),
    .status_o       (status_o),
    .slot_id_o      (slot_id_o),
    .last_o         (last_o)
  );

endmodule
`default_nettype wire
